>>> sv/stl_pkg.sv
// Package for the source token lexer: token kinds, error codes, token and
// queue entry types, character constants and byte class helpers.
// No dependencies.
package stl_pkg;

  // Widths and limits
  localparam int unsigned POS_W   = 32;
  localparam int unsigned LEN_W   = 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(255);
  localparam int unsigned TQ_DEPTH = 4;
  localparam int unsigned TQ_AW    = 2;

  // Token kinds
  typedef enum logic [4:0] {
    TK_END    = 5'd0,
    TK_ERROR  = 5'd1,
    TK_IDENT  = 5'd2,
    TK_NUMBER = 5'd3,
    TK_PLUS   = 5'd4,
    TK_MINUS  = 5'd5,
    TK_LPAREN = 5'd6,
    TK_RPAREN = 5'd7,
    TK_MUL    = 5'd8,
    TK_DIV    = 5'd9,
    TK_LT     = 5'd10,
    TK_LE     = 5'd11,
    TK_GT     = 5'd12,
    TK_GE     = 5'd13,
    TK_ASSIGN = 5'd14,
    TK_EQ     = 5'd15,
    TK_NOT    = 5'd16,
    TK_NE     = 5'd17,
    TK_BITAND = 5'd18,
    TK_AND    = 5'd19,
    TK_BITOR  = 5'd20,
    TK_OR     = 5'd21
  } tok_kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_UNDERSCORE = 3'd2,
    ERR_DOT        = 3'd3,
    ERR_UNCLOSED   = 3'd4
  } err_code_t;

  typedef struct packed {
    tok_kind_t        kind;
    err_code_t        err;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
  } tok_t;

  // One queue entry: a token plus its end-of-item marker
  typedef struct packed {
    logic last;
    tok_t tok;
  } ent_t;

  // Up to two tokens produced by one item, compacted into e0 first
  typedef struct packed {
    logic [1:0] num;
    ent_t       e0;
    ent_t       e1;
  } tok_pair_t;

  // Character constants
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> sv/source_token_lexer.sv
// Source token lexer: one ASCII byte (or an end-of-input mark) per input beat
// turns into zero, one or two tokens. Each accepted beat is held in an input
// register, then the lexer core updates its state and pushes its tokens into
// a four-entry token queue that feeds the output. A new byte can be taken
// every cycle while the queue has room for two tokens, so the sustained rate
// is one byte per cycle, limited only by the output draining one token per
// beat; a byte that both ends a pending token and yields its own needs two
// output beats. Depends on stl_pkg, stl_core and stl_tok_fifo.
module source_token_lexer import stl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] end_of_input
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [4:0] token_kind, [7:5] error_code,
                                  // [39:8] start_offset, [47:40] lexeme_length
  output logic        out_tlast   // last token of the input beat
);

  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_eoi_r;
  logic       step;
  logic       room2;
  tok_pair_t  toks;
  ent_t       head;

  // Input register
  assign step      = in_vld_r && room2;
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_eoi_r  <= in_tuser;
    end
  end

  // Lexer state and token logic
  stl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .char_i (in_char_r),
    .eoi_i  (in_eoi_r),
    .toks   (toks)
  );

  // Token queue toward the output
  stl_tok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (step),
    .wr_data  (toks),
    .rd_en    (out_tready),
    .rd_valid (out_tvalid),
    .rd_data  (head),
    .room2    (room2)
  );

  assign out_tdata = {head.tok.len, head.tok.start, head.tok.err, head.tok.kind};
  assign out_tlast = head.last;

  // End token always closes its beat and has no lexeme
  a_end_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (head.tok.kind == TK_END)) |-> (out_tlast && (head.tok.len == '0)))
    else $error("end token without tlast or with nonzero length");

  // Only error tokens carry an error code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (head.tok.kind != TK_ERROR)) |-> (head.tok.err == ERR_NONE))
    else $error("error code on a non-error token");

  // An accepted input beat is held in the input register next cycle
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> in_vld_r)
    else $error("accepted input beat lost");

  // The core never processes an item without queue space
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !room2) |-> !step)
    else $error("item processed while token queue full");

endmodule

>>> sv/stl_core.sv
// Lexer core: lexer state, stream position and pending lexeme registers,
// and the combinational next-state and token logic. Depends on stl_pkg.
module stl_core import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_i,
  input  logic       eoi_i,
  output tok_pair_t  toks
);

  typedef enum logic [3:0] {
    S_START      = 4'd0,
    S_UNDERSCORE = 4'd1,
    S_IDENT      = 4'd2,
    S_INT        = 4'd3,
    S_DOT        = 4'd4,
    S_FRAC       = 4'd5,
    S_LT         = 4'd6,
    S_GT         = 4'd7,
    S_ASSIGN     = 4'd8,
    S_NOT        = 4'd9,
    S_AMP        = 4'd10,
    S_BAR        = 4'd11,
    S_SLASH      = 4'd12,
    S_LINE       = 4'd13,
    S_BLOCK      = 4'd14,
    S_BLOCK_STAR = 4'd15
  } lex_state_t;

  lex_state_t       st_r, st_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ts_r, ts_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;

  logic [LEN_W-1:0] bumped;
  logic             fh;
  tok_kind_t        fk;
  err_code_t        fe;
  logic             va, vb, cons, fl_ok, idc;
  tok_t             ta, tb;
  logic [7:0]       want;
  tok_kind_t        pk;

  // Saturating lexeme length
  assign bumped = (cnt_r == MAX_LEN) ? cnt_r : cnt_r + LEN_W'(1);
  assign idc    = is_letter(char_i) || is_digit(char_i) || (char_i == CH_USCORE);

  // Token that a pending lexeme turns into when it is cut off
  always_comb begin
    fh = 1'b1;
    fk = TK_ERROR;
    fe = ERR_NONE;
    unique case (st_r)
      S_UNDERSCORE: fe = ERR_UNDERSCORE;
      S_IDENT:      fk = TK_IDENT;
      S_INT, S_FRAC: fk = TK_NUMBER;
      S_DOT:        fe = ERR_DOT;
      S_LT:         fk = TK_LT;
      S_GT:         fk = TK_GT;
      S_ASSIGN:     fk = TK_ASSIGN;
      S_NOT:        fk = TK_NOT;
      S_AMP:        fk = TK_BITAND;
      S_BAR:        fk = TK_BITOR;
      S_SLASH:      fk = TK_DIV;
      S_BLOCK, S_BLOCK_STAR: fe = ERR_UNCLOSED;
      default:      fh = 1'b0;
    endcase
  end

  // Paired operator: second byte wanted and the combined kind
  always_comb begin
    want = CH_EQ;
    pk   = TK_LE;
    unique case (st_r)
      S_GT:     pk = TK_GE;
      S_ASSIGN: pk = TK_EQ;
      S_NOT:    pk = TK_NE;
      S_AMP:    begin want = CH_AMP; pk = TK_AND; end
      S_BAR:    begin want = CH_BAR; pk = TK_OR;  end
      default:  ;
    endcase
  end

  // Next state and tokens for one item
  always_comb begin
    st_nxt  = st_r;
    pos_nxt = pos_r + POS_W'(1);
    ts_nxt  = ts_r;
    cnt_nxt = cnt_r;
    va      = 1'b0;
    vb      = 1'b0;
    ta      = '{kind: fk, err: fe, start: ts_r, len: cnt_r};
    tb      = '{kind: TK_END, err: ERR_NONE, start: pos_r, len: '0};
    cons    = 1'b0;
    fl_ok   = 1'b1;
    if (eoi_i) begin
      // flush, end token, back to reset values
      va      = fh;
      vb      = 1'b1;
      st_nxt  = S_START;
      pos_nxt = '0;
      ts_nxt  = '0;
      cnt_nxt = '0;
    end else begin
      // try to extend the pending lexeme
      unique case (st_r)
        S_UNDERSCORE, S_IDENT: begin
          if (idc) begin
            cons = 1'b1; st_nxt = S_IDENT; cnt_nxt = bumped;
          end
        end
        S_INT: begin
          if (is_digit(char_i)) begin
            cons = 1'b1; cnt_nxt = bumped;
          end else if (char_i == CH_DOT) begin
            cons = 1'b1; st_nxt = S_DOT; cnt_nxt = bumped;
          end
        end
        S_DOT, S_FRAC: begin
          if (is_digit(char_i)) begin
            cons = 1'b1; st_nxt = S_FRAC; cnt_nxt = bumped;
          end
        end
        S_LT, S_GT, S_ASSIGN, S_NOT, S_AMP, S_BAR: begin
          if (char_i == want) begin
            cons    = 1'b1;
            va      = 1'b1;
            ta      = '{kind: pk, err: ERR_NONE, start: ts_r, len: bumped};
            st_nxt  = S_START;
            cnt_nxt = '0;
          end
        end
        S_SLASH: begin
          if (char_i == CH_SLASH) begin
            cons = 1'b1; st_nxt = S_LINE; cnt_nxt = '0;
          end else if (char_i == CH_STAR) begin
            cons = 1'b1; st_nxt = S_BLOCK; cnt_nxt = bumped;
          end
        end
        S_LINE: begin
          if (char_i == CH_NUL) begin
            fl_ok = 1'b0;
          end else begin
            cons = 1'b1;
            if ((char_i == CH_LF) || (char_i == CH_CR)) st_nxt = S_START;
          end
        end
        S_BLOCK, S_BLOCK_STAR: begin
          if (char_i == CH_NUL) begin
            // null byte abandons the comment without a flush
            fl_ok = 1'b0;
          end else begin
            cons    = 1'b1;
            cnt_nxt = bumped;
            if (char_i == CH_STAR) begin
              st_nxt = S_BLOCK_STAR;
            end else if ((st_r == S_BLOCK_STAR) && (char_i == CH_SLASH)) begin
              st_nxt  = S_START;
              cnt_nxt = '0;
            end else begin
              st_nxt = S_BLOCK;
            end
          end
        end
        default: ;
      endcase

      // byte ends the lexeme: flush it, then start over with this byte
      if (!cons) begin
        va      = fh && fl_ok;
        st_nxt  = S_START;
        cnt_nxt = '0;
        tb      = '{kind: TK_ERROR, err: ERR_UNEXPECTED, start: pos_r, len: LEN_W'(1)};
        if (is_digit(char_i)) begin
          st_nxt = S_INT; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (is_letter(char_i)) begin
          st_nxt = S_IDENT; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_USCORE) begin
          st_nxt = S_UNDERSCORE; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_PLUS) begin
          vb = 1'b1; tb.kind = TK_PLUS; tb.err = ERR_NONE;
        end else if (char_i == CH_MINUS) begin
          vb = 1'b1; tb.kind = TK_MINUS; tb.err = ERR_NONE;
        end else if (char_i == CH_LPAREN) begin
          vb = 1'b1; tb.kind = TK_LPAREN; tb.err = ERR_NONE;
        end else if (char_i == CH_RPAREN) begin
          vb = 1'b1; tb.kind = TK_RPAREN; tb.err = ERR_NONE;
        end else if (char_i == CH_STAR) begin
          vb = 1'b1; tb.kind = TK_MUL; tb.err = ERR_NONE;
        end else if (char_i == CH_LT) begin
          st_nxt = S_LT; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_GT) begin
          st_nxt = S_GT; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_EQ) begin
          st_nxt = S_ASSIGN; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_BANG) begin
          st_nxt = S_NOT; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_AMP) begin
          st_nxt = S_AMP; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_BAR) begin
          st_nxt = S_BAR; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (char_i == CH_SLASH) begin
          st_nxt = S_SLASH; ts_nxt = pos_r; cnt_nxt = LEN_W'(1);
        end else if (!is_space(char_i)) begin
          vb = 1'b1;
        end
      end
    end
  end

  // Compact the two slots; last marks the final token of the item
  always_comb begin
    toks.num     = {1'b0, va} + {1'b0, vb};
    toks.e0.tok  = va ? ta : tb;
    toks.e0.last = !(va && vb);
    toks.e1.tok  = tb;
    toks.e1.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_START;
      pos_r <= '0;
      ts_r  <= '0;
      cnt_r <= '0;
    end else if (step) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
      ts_r  <= ts_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/stl_tok_fifo.sv
// Token queue: takes zero, one or two tokens a cycle and hands out one
// token a beat. Depends on stl_pkg.
module stl_tok_fifo import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  tok_pair_t wr_data,
  input  logic      rd_en,
  output logic      rd_valid,
  output ent_t      rd_data,
  output logic      room2
);

  ent_t             mem_r [TQ_DEPTH];
  logic [TQ_AW-1:0] wp_r, wp_nxt;
  logic [TQ_AW-1:0] rp_r, rp_nxt;
  logic [TQ_AW:0]   cnt_r, cnt_nxt;
  logic [1:0]       wr_num;

  assign wr_num   = wr_en ? wr_data.num : 2'd0;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  // room for a full two-token item
  assign room2    = (cnt_r <= (TQ_AW+1)'(TQ_DEPTH - 2));

  // Pointer and fill arithmetic
  always_comb begin
    wp_nxt  = wp_r + TQ_AW'(wr_num);
    rp_nxt  = rp_r + TQ_AW'(rd_en && rd_valid);
    cnt_nxt = cnt_r + (TQ_AW+1)'(wr_num) - (TQ_AW+1)'(rd_en && rd_valid);
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (wr_num != 2'd0) mem_r[wp_r] <= wr_data.e0;
    if (wr_num == 2'd2) mem_r[wp_r + TQ_AW'(1)] <= wr_data.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
